FILE: sv/rism_pkg.sv
// Shared types and constants for the radial iris sparkle mask unit.
// Depends on nothing; used by rism_cfg, radial_iris_sparkle_mask_unit and the testbench.
package rism_pkg;

	localparam int unsigned P_MAX_DIM = 4096;

	localparam int unsigned CFG_W  = 13;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned OFS_W  = 11;
	localparam int unsigned RND_W  = 32;
	localparam int unsigned CRD_W  = 12;
	localparam int unsigned LVL_W  = 8;
	localparam int unsigned DITH_W = 5;
	localparam int unsigned NQUAD  = 4;
	localparam int unsigned SQR_W  = 2 * OFS_W;
	localparam int unsigned SUM_W  = SQR_W + 1;
	localparam int unsigned SCALE_W = 16;
	localparam logic [SCALE_W-1:0] LEVEL_SCALE_SQ = 16'd50176;
	localparam int unsigned NUM_W  = SUM_W + SCALE_W;
	localparam int unsigned QUO_W  = 14;
	localparam int unsigned ROOT_W = 7;

	localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
	localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

	localparam int unsigned IN_DATA_W  = 56;
	localparam int unsigned OUT_DATA_W = 80;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 4'd0,
		REG_FRAME_HEIGHT = 4'd1
	} reg_idx_t;

	typedef struct packed {
		logic [NQUAD*DITH_W-1:0] dither;
		logic [CRD_W-1:0]        row_lower;
		logic [CRD_W-1:0]        row_upper;
		logic [CRD_W-1:0]        col_right;
		logic [CRD_W-1:0]        col_left;
	} side_t;

endpackage

FILE: sv/rism_cfg.sv
// Configuration registers of the mask unit and the frame constants derived from them.
// Depends on rism_pkg.
module rism_cfg import rism_pkg::*; #(
	parameter int unsigned MAX_DIM = P_MAX_DIM,
	parameter int unsigned DIM_W   = $clog2(MAX_DIM + 1),
	parameter int unsigned DEN_W   = 2 * DIM_W + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [DIM_W-1:0]      dim_w,
	output logic [DIM_W-1:0]      dim_h,
	output logic [DIM_W-1:0]      half_w,
	output logic [DIM_W-1:0]      half_h,
	output logic [DEN_W-1:0]      den
);

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [DEN_W-1:0] den_q;
	logic [DIM_W:0]   w_inc;
	logic [DIM_W:0]   h_inc;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] raw);
		logic [DIM_W-1:0] res;
		if (raw == '0) begin
			res = DIM_W'(1);
		end else if (32'(raw) > 32'(MAX_DIM)) begin
			res = DIM_W'(MAX_DIM);
		end else begin
			res = DIM_W'(raw);
		end
		return res;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data[CFG_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	assign dim_w  = eff_dim(width_q);
	assign dim_h  = eff_dim(height_q);
	assign w_inc  = {1'b0, dim_w} + 1'b1;
	assign h_inc  = {1'b0, dim_h} + 1'b1;
	assign half_w = w_inc[DIM_W:1];
	assign half_h = h_inc[DIM_W:1];

	// The divisor is registered; it is stable long before any request reaches the divider.
	always_ff @(posedge clk) begin
		den_q <= DEN_W'(dim_w) * DEN_W'(dim_w) + DEN_W'(dim_h) * DEN_W'(dim_h);
	end

	assign den = den_q;

endmodule

FILE: sv/radial_iris_sparkle_mask_unit.sv
// Top level of the radial iris sparkle mask unit: clamp, squares, divider and square root pipeline.
// Depends on rism_pkg and rism_cfg.
//
// Each request on the s_axis channel carries a quadrant offset from the frame center and a
// random word. The m_axis channel returns the four mirrored coordinates and four dithered
// levels, where the base level is isqrt(50176 * (x*x + y*y) / (w*w + h*h)).
// Frame width and height are written through the cfg channel, which is always ready; write
// them only while no request is in flight.
// The pipeline has 25 register stages. One request is taken every cycle unless a stall on
// m_axis has filled the stages ahead of the input; the restoring divider retires one quotient
// bit per stage and the square root one root bit per stage.
// Each stage holds its data while the stage after it is full and stalled, so an empty stage
// still takes a request while the output waits. A stall on m_axis loses nothing.
// Reset clears all valid bits and loads a 640 by 480 frame.
module radial_iris_sparkle_mask_unit import rism_pkg::*; #(
	parameter int unsigned MAX_DIM = P_MAX_DIM
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// offset_x [10:0], offset_y [21:11], random_word [53:22], zero [55:54]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// col_left [11:0], col_right [23:12], row_upper [35:24], row_lower [47:36],
	// level_upper_left [55:48], level_upper_right [63:56],
	// level_lower_left [71:64], level_lower_right [79:72]
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
	localparam int unsigned DEN_W = 2 * DIM_W + 1;
	localparam int unsigned REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
	localparam int unsigned DIV0  = 3;
	localparam int unsigned SQ0   = DIV0 + QUO_W;
	localparam int unsigned NSTG  = SQ0 + ROOT_W + 1;

	logic [DIM_W-1:0] dim_w;
	logic [DIM_W-1:0] dim_h;
	logic [DIM_W-1:0] half_w;
	logic [DIM_W-1:0] half_h;
	logic [DEN_W-1:0] den;

	rism_cfg #(
		.MAX_DIM(MAX_DIM),
		.DIM_W  (DIM_W),
		.DEN_W  (DEN_W)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.dim_w    (dim_w),
		.dim_h    (dim_h),
		.half_w   (half_w),
		.half_h   (half_h),
		.den      (den)
	);

	logic [NSTG-1:0] vld_q;
	logic [NSTG:0]   en;

	always_comb begin
		en[NSTG] = m_axis_tready;
		for (int k = NSTG - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_axis_tvalid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_axis_tready = en[0];
	assign m_axis_tvalid = vld_q[NSTG-1];

	// Stage 1: clamp and mirrored coordinates.
	logic [OFS_W-1:0] in_x;
	logic [OFS_W-1:0] in_y;
	logic [RND_W-1:0] in_rnd;
	logic [DIM_W-1:0] lim_x;
	logic [DIM_W-1:0] lim_y;
	logic [OFS_W-1:0] cx;
	logic [OFS_W-1:0] cy;
	logic [DIM_W-1:0] cl_full;
	logic [DIM_W-1:0] ru_full;
	side_t            side_in;

	assign in_x   = s_axis_tdata[OFS_W-1:0];
	assign in_y   = s_axis_tdata[2*OFS_W-1:OFS_W];
	assign in_rnd = s_axis_tdata[2*OFS_W+RND_W-1:2*OFS_W];
	assign lim_x  = half_w - 1'b1;
	assign lim_y  = half_h - 1'b1;
	assign cx = (32'(in_x) > 32'(lim_x)) ? OFS_W'(lim_x) : in_x;
	assign cy = (32'(in_y) > 32'(lim_y)) ? OFS_W'(lim_y) : in_y;
	assign cl_full = lim_x - DIM_W'(cx);
	assign ru_full = lim_y - DIM_W'(cy);

	always_comb begin
		side_in.col_left  = CRD_W'(cl_full);
		side_in.col_right = CRD_W'(dim_w - cl_full - 1'b1);
		side_in.row_upper = CRD_W'(ru_full);
		side_in.row_lower = CRD_W'(dim_h - ru_full - 1'b1);
		for (int k = 0; k < NQUAD; k++) begin
			side_in.dither[k*DITH_W +: DITH_W] = in_rnd[k*8 +: DITH_W];
		end
	end

	logic [OFS_W-1:0] x_s1;
	logic [OFS_W-1:0] y_s1;
	side_t            side_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1    <= cx;
			y_s1    <= cy;
			side_s1 <= side_in;
		end
	end

	// Stage 2: sum of squares.
	logic [SUM_W-1:0] sum_s2;
	side_t            side_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sum_s2  <= SUM_W'(SQR_W'(x_s1) * SQR_W'(x_s1)) +
				SUM_W'(SQR_W'(y_s1) * SQR_W'(y_s1));
			side_s2 <= side_s1;
		end
	end

	// Stage 3: scaled numerator.
	logic [NUM_W-1:0] num_s3;
	side_t            side_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			num_s3  <= NUM_W'(sum_s2) * NUM_W'(LEVEL_SCALE_SQ);
			side_s3 <= side_s2;
		end
	end

	// Restoring divider, one quotient bit per stage, most significant first.
	logic [REM_W-1:0] rem_s  [QUO_W];
	logic [QUO_W-1:0] quo_s  [QUO_W];
	side_t            dside_s [QUO_W];

	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		logic [REM_W-1:0] rem_in;
		logic [QUO_W-1:0] quo_in;
		side_t            side_prev;
		logic [REM_W-1:0] dsh;
		logic             take;

		if (j == 0) begin : g_first
			assign rem_in    = REM_W'(num_s3);
			assign quo_in    = '0;
			assign side_prev = side_s3;
		end else begin : g_next
			assign rem_in    = rem_s[j-1];
			assign quo_in    = quo_s[j-1];
			assign side_prev = dside_s[j-1];
		end

		assign dsh  = REM_W'(den) << (QUO_W - 1 - j);
		assign take = rem_in >= dsh;

		always_ff @(posedge clk) begin
			if (en[DIV0+j]) begin
				rem_s[j]   <= take ? rem_in - dsh : rem_in;
				quo_s[j]   <= quo_in | (take ? (QUO_W'(1) << (QUO_W - 1 - j)) : '0);
				dside_s[j] <= side_prev;
			end
		end
	end

	// Square root, one root bit per stage, most significant first.
	logic [QUO_W-1:0]  rad_s   [ROOT_W];
	logic [ROOT_W-1:0] root_s  [ROOT_W];
	side_t             rside_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		logic [QUO_W-1:0]  rad_in;
		logic [ROOT_W-1:0] root_in;
		side_t             side_prev;
		logic [ROOT_W-1:0] trial;
		logic [QUO_W-1:0]  trial_sq;

		if (k == 0) begin : g_first
			assign rad_in    = quo_s[QUO_W-1];
			assign root_in   = '0;
			assign side_prev = dside_s[QUO_W-1];
		end else begin : g_next
			assign rad_in    = rad_s[k-1];
			assign root_in   = root_s[k-1];
			assign side_prev = rside_s[k-1];
		end

		assign trial    = root_in | (ROOT_W'(1) << (ROOT_W - 1 - k));
		assign trial_sq = QUO_W'(trial) * QUO_W'(trial);

		always_ff @(posedge clk) begin
			if (en[SQ0+k]) begin
				rad_s[k]   <= rad_in;
				root_s[k]  <= (trial_sq <= rad_in) ? trial : root_in;
				rside_s[k] <= side_prev;
			end
		end
	end

	// Output stage: dithered levels.
	side_t                   side_out;
	logic [NQUAD*LVL_W-1:0]  lvl_in;
	logic [NQUAD*LVL_W-1:0]  lvl_out;
	side_t                   side_fin;

	assign side_fin = rside_s[ROOT_W-1];

	always_comb begin
		for (int k = 0; k < NQUAD; k++) begin
			lvl_in[k*LVL_W +: LVL_W] = LVL_W'(root_s[ROOT_W-1]) +
				LVL_W'(side_fin.dither[k*DITH_W +: DITH_W]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[NSTG-1]) begin
			side_out <= side_fin;
			lvl_out  <= lvl_in;
		end
	end

	assign m_axis_tdata = {lvl_out, side_out.row_lower, side_out.row_upper,
		side_out.col_right, side_out.col_left};

endmodule

FILE: tb/tb_radial_iris_sparkle_mask_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for radial_iris_sparkle_mask_unit: directed table, then random requests.
// Depends on rism_pkg and the unit; predicts each result in its own terms and checks in order.
module tb_radial_iris_sparkle_mask_unit;
	import rism_pkg::*;

	localparam int LATENCY = 25;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 650;
	localparam int MAX_DIM_TB = P_MAX_DIM;

	typedef struct packed {
		logic [OFS_W-1:0] ofs_x;
		logic [OFS_W-1:0] ofs_y;
		logic [RND_W-1:0] rnd;
	} pixel_req_t;

	typedef struct packed {
		logic [CRD_W-1:0] col_l;
		logic [CRD_W-1:0] col_r;
		logic [CRD_W-1:0] row_u;
		logic [CRD_W-1:0] row_d;
		logic [LVL_W-1:0] lvl_ul;
		logic [LVL_W-1:0] lvl_ur;
		logic [LVL_W-1:0] lvl_ll;
		logic [LVL_W-1:0] lvl_lr;
	} mask_pixel_t;

	typedef struct {
		logic [OFS_W-1:0] ofs_x;
		logic [OFS_W-1:0] ofs_y;
		logic [RND_W-1:0] rnd;
		logic             has_gold;
		mask_pixel_t      gold;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	logic [CFG_W-1:0] width_reg = RESET_WIDTH;
	logic [CFG_W-1:0] height_reg = RESET_HEIGHT;
	mask_pixel_t pending_pixels[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_idle_pct = 34;
	int recv_idle_pct = 59;
	table_row_t directed[$];

	radial_iris_sparkle_mask_unit dut (.*);

	always #5 clk = ~clk;

	function automatic logic [63:0] root_of(logic [63:0] n);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic [63:0] usable_dim(logic [CFG_W-1:0] raw);
		if (raw == 0) return 64'd1;
		if (raw > MAX_DIM_TB) return 64'(MAX_DIM_TB);
		return 64'(raw);
	endfunction

	function automatic mask_pixel_t predict_pixel(pixel_req_t req);
		logic [63:0] w, h, hw, hh, x, y, cl, ru, q, v;
		mask_pixel_t p;
		w = usable_dim(width_reg);
		h = usable_dim(height_reg);
		hw = (w + 1) / 2;
		hh = (h + 1) / 2;
		x = 64'(req.ofs_x);
		y = 64'(req.ofs_y);
		if (x > hw - 1) x = hw - 1;
		if (y > hh - 1) y = hh - 1;
		cl = hw - x - 1;
		ru = hh - y - 1;
		q = (64'd50176 * (x * x + y * y)) / (w * w + h * h);
		v = root_of(q);
		p.col_l = cl[CRD_W-1:0];
		p.col_r = 12'(w - cl - 1);
		p.row_u = ru[CRD_W-1:0];
		p.row_d = 12'(h - ru - 1);
		p.lvl_ul = 8'(v + req.rnd[4:0]);
		p.lvl_ur = 8'(v + req.rnd[12:8]);
		p.lvl_ll = 8'(v + req.rnd[20:16]);
		p.lvl_lr = 8'(v + req.rnd[28:24]);
		return p;
	endfunction

	function automatic logic [OUT_DATA_W-1:0] pack_pixel(mask_pixel_t p);
		return {p.lvl_lr, p.lvl_ll, p.lvl_ur, p.lvl_ul, p.row_d, p.row_u, p.col_r, p.col_l};
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
				errors++;
			end else begin
				logic [OUT_DATA_W-1:0] want;
				want = pack_pixel(pending_pixels.pop_front());
				if (m_axis_tdata !== want) begin
					$display("%0t: mismatch, expected %h, actual %h", $time, want, m_axis_tdata);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_FRAME_WIDTH) width_reg = val[CFG_W-1:0];
		else width_reg = width_reg;
		if (idx == REG_FRAME_HEIGHT) height_reg = val[CFG_W-1:0];
	endtask

	task automatic write_index(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_FRAME_WIDTH) width_reg = val[CFG_W-1:0];
		else if (idx == REG_FRAME_HEIGHT) height_reg = val[CFG_W-1:0];
	endtask

	task automatic send_pixel(pixel_req_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, req.rnd, req.ofs_y, req.ofs_x};
		do @(posedge clk); while (!s_axis_tready);
		pending_pixels.push_back(predict_pixel(req));
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		pixel_req_t req;
		for (int i = 0; i < count; i++) begin
			req.rnd = $urandom();
			case ($urandom_range(3))
				0: begin
					req.ofs_x = OFS_W'($urandom());
					req.ofs_y = OFS_W'($urandom());
				end
				1: begin
					req.ofs_x = OFS_W'($urandom_range(32'((usable_dim(width_reg) + 1) / 2)));
					req.ofs_y = OFS_W'($urandom_range(32'((usable_dim(height_reg) + 1) / 2)));
				end
				default: begin
					req.ofs_x = OFS_W'($urandom_range(2047) >> $urandom_range(11));
					req.ofs_y = OFS_W'($urandom_range(2047) >> $urandom_range(11));
				end
			endcase
			send_pixel(req);
		end
	endtask

	initial begin
		mask_pixel_t g;
		pixel_req_t req;
		table_row_t row;
		int phase;

		// Reset frame 640x480 at the center: base level zero, levels equal the dither bits.
		g = '{col_l: 12'd319, col_r: 12'd320, row_u: 12'd239, row_d: 12'd240,
			lvl_ul: 8'd0, lvl_ur: 8'd0, lvl_ll: 8'd0, lvl_lr: 8'd0};
		directed.push_back('{11'd0, 11'd0, 32'h0, 1'b1, g});
		g = '{col_l: 12'd319, col_r: 12'd320, row_u: 12'd239, row_d: 12'd240,
			lvl_ul: 8'd31, lvl_ur: 8'd31, lvl_ll: 8'd31, lvl_lr: 8'd31};
		directed.push_back('{11'd0, 11'd0, 32'hffff_ffff, 1'b1, g});
		// Clamped corner: both offsets beyond the quadrant land on column and row zero.
		g = '{col_l: 12'd0, col_r: 12'd639, row_u: 12'd0, row_d: 12'd479,
			lvl_ul: 8'd0, lvl_ur: 8'd0, lvl_ll: 8'd0, lvl_lr: 8'd0};
		directed.push_back('{11'd2047, 11'd2047, 32'h0, 1'b0, g});
		directed.push_back('{11'd319, 11'd239, 32'h1f00_1f00, 1'b0, g});
		directed.push_back('{11'd320, 11'd0, 32'h001f_001f, 1'b0, g});
		directed.push_back('{11'd0, 11'd240, 32'haaaa_aaaa, 1'b0, g});
		directed.push_back('{11'd1024, 11'd5, 32'h5555_5555, 1'b0, g});
		directed.push_back('{11'd7, 11'd1024, 32'he0e0_e0e0, 1'b0, g});

		#1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			row = directed[i];
			req = '{row.ofs_x, row.ofs_y, row.rnd};
			if (row.has_gold && predict_pixel(req) != row.gold) begin
				$display("%0t: table mismatch row %0d, expected %h, actual %h", $time, i,
					pack_pixel(row.gold), pack_pixel(predict_pixel(req)));
				errors++;
			end
			send_pixel(req);
		end
		drain();

		// Frame sizes: zero, one, odd, max, above max, unused index, 1920x1080 and random sizes.
		for (phase = 0; phase < 9; phase++) begin
			send_idle_pct = (phase < 3) ? 34 : (phase < 6) ? 59 : 0;
			recv_idle_pct = (phase < 3) ? 59 : (phase < 6) ? 34 : 0;
			case (phase)
				0: begin write_reg(REG_FRAME_WIDTH, 16'd0); write_reg(REG_FRAME_HEIGHT, 16'd1); end
				1: begin write_reg(REG_FRAME_WIDTH, 16'd4096); write_reg(REG_FRAME_HEIGHT, 16'd4096); end
				2: begin write_reg(REG_FRAME_WIDTH, 16'hffff); write_reg(REG_FRAME_HEIGHT, 16'd4097); end
				3: begin write_reg(REG_FRAME_WIDTH, 16'd33); write_reg(REG_FRAME_HEIGHT, 16'd17); end
				4: begin write_reg(REG_FRAME_WIDTH, 16'd1); write_reg(REG_FRAME_HEIGHT, 16'd4096); end
				5: begin write_index(4'hf, 16'd7); write_reg(REG_FRAME_HEIGHT, 16'h1555); end
				6: begin write_reg(REG_FRAME_WIDTH, 16'd1920); write_reg(REG_FRAME_HEIGHT, 16'd1080); end
				7: begin write_index(4'd2, 16'hffff); write_reg(REG_FRAME_WIDTH, 16'h0aaa); end
				default: begin
					write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(1, 4096)));
					write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(1, 4096)));
				end
			endcase
			random_phase(RANDOM_ITEMS / 9);
			drain();
		end

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
